FILE: sv/keyed_address_table_unit_defines.svh
// Assertion macros for the keyed address table checker.
`ifndef KEYED_ADDRESS_TABLE_UNIT_DEFINES_SVH
`define KEYED_ADDRESS_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define KAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define KAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/kat_pkg.sv
// Shared types and constants of the keyed address table.
package kat_pkg;

  localparam int CAPACITY  = 16;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KEY_W     = 32;
  localparam int ADDR_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_DUP     = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_MISSING = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_KEY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_ADDRESS = 2'd1;

  typedef struct packed {
    logic [1:0]        command;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] entry_address;
  } kat_req_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] result_address;
    logic [1:0]        status;
  } kat_rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] address;
  } kat_entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    kat_entry_t       wr_data;
    logic [IDX_W-1:0] rd_addr;
  } kat_mem_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } kat_state_t;

endpackage

FILE: sv/keyed_address_table_unit.sv
// Top level of the keyed address table: sequencer plus slot memory.
//
// Keyed address table. Maps 32-bit key ids to 32-bit addresses in a table of
// CAPACITY (16) slots, kept packed in slots 0 .. used_count-1, next to an
// origin key/address pair held in two configuration registers (index 0 origin
// key, index 1 origin address). Each request word carries a command (insert,
// remove, lookup), a key and an address; each produces exactly one response
// word with found, result_address and status (ok, duplicate, full, not found).
// The block works on one request at a time and holds req_ready low until the
// response is loaded into the output register. The single key comparator
// walks the slot memory through its one read port, one slot per cycle; a
// remove that hits also pulls every later slot down one place, one slot per
// cycle. A request waits in its final state while a previous response still
// sits in the output register. The response register lets the next request
// be accepted while a response still waits for rsp_ready. Write the
// configuration registers only while the block is idle. Removing the origin
// key clears the origin only when no entries are stored; once cleared it
// never matches again and the key may be inserted as an ordinary entry.
module keyed_address_table_unit
  import kat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 req_valid,
  output logic                 req_ready,
  input  kat_req_t             req,
  // response channel
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output kat_rsp_t             rsp,
  // configuration write port
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  kat_mem_t   mem_req;
  kat_entry_t rd_data;

  // sequencer: origin check, slot scan, compaction and response
  kat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  // slot storage; contents at and above used_count are never used
  kat_table u_table (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

FILE: sv/kat_table.sv
// Slot memory: one write port, one read port with registered read data.
module kat_table
  import kat_pkg::*;
(
  input  logic       clk,
  input  kat_mem_t   mem_req,
  output kat_entry_t rd_data
);

  kat_entry_t slots [CAPACITY];

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      slots[mem_req.wr_addr] <= mem_req.wr_data;
    end
    rd_data <= slots[mem_req.rd_addr];
  end

endmodule

FILE: sv/kat_ctrl.sv
// Command sequencer with the shared key comparator, origin registers and result register.
module kat_ctrl
  import kat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  kat_req_t             req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output kat_rsp_t             rsp,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output kat_mem_t             mem_req,
  input  kat_entry_t           rd_data
);

  kat_state_t        state, state_next;
  logic [1:0]        cmd, cmd_next;
  logic [KEY_W-1:0]  key, key_next;
  logic [ADDR_W-1:0] ent_addr, ent_addr_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic              pend, pend_next;
  logic [IDX_W-1:0]  pend_idx, pend_idx_next;
  logic [CNT_W-1:0]  used_count, used_count_next;
  logic              origin_live, origin_live_next;
  logic [KEY_W-1:0]  origin_key;
  logic [ADDR_W-1:0] origin_address;
  kat_rsp_t          res, res_next;
  kat_rsp_t          rsp_next;
  logic              rsp_valid_next;

  logic key_zero;
  logic origin_hit;
  logic key_match;
  logic scan_hit;
  logic scan_end;
  logic shift_done;
  logic out_free;

  assign key_zero   = (key == '0);
  assign origin_hit = origin_live && !key_zero && (key == origin_key);
  // the one shared comparator: stored key against the command's key
  assign key_match  = (rd_data.key == key);
  assign scan_hit   = pend && key_match;
  assign scan_end   = !scan_hit && (idx >= used_count);
  assign shift_done = !pend && (idx >= used_count);
  assign out_free   = !rsp_valid || rsp_ready;
  assign req_ready  = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        case (cmd)
          CMD_INSERT: begin
            state_next = (key_zero || origin_hit) ? S_DONE : S_SCAN;
          end
          CMD_REMOVE: begin
            state_next = (key_zero || (origin_hit && used_count == '0)) ? S_DONE : S_SCAN;
          end
          CMD_LOOKUP: begin
            state_next = (key_zero || origin_hit) ? S_DONE : S_SCAN;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_next = (cmd == CMD_REMOVE) ? S_SHIFT : S_DONE;
        end else if (scan_end) begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        if (shift_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_next         = cmd;
    key_next         = key;
    ent_addr_next    = ent_addr;
    idx_next         = idx;
    pend_next        = pend;
    pend_idx_next    = pend_idx;
    used_count_next  = used_count;
    origin_live_next = origin_live;
    res_next         = res;
    rsp_next         = rsp;
    rsp_valid_next   = rsp_valid && !rsp_ready;
    mem_req.wr_en    = 1'b0;
    mem_req.wr_addr  = pend_idx;
    mem_req.wr_data  = rd_data;
    mem_req.rd_addr  = idx[IDX_W-1:0];

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd_next      = req.command;
          key_next      = req.key;
          ent_addr_next = req.entry_address;
          idx_next      = '0;
          pend_next     = 1'b0;
          res_next      = '0;
        end
      end
      S_CHECK: begin
        case (cmd)
          CMD_INSERT: begin
            if (key_zero) begin
              res_next.status = STAT_MISSING;
            end else if (origin_hit) begin
              res_next.status = STAT_DUP;
            end
          end
          CMD_REMOVE: begin
            if (key_zero) begin
              res_next.status = STAT_MISSING;
            end else if (origin_hit && used_count == '0) begin
              origin_live_next = 1'b0;
            end
          end
          CMD_LOOKUP: begin
            if (origin_hit) begin
              res_next.found          = 1'b1;
              res_next.result_address = origin_address;
            end else if (key_zero) begin
              res_next.status = STAT_MISSING;
            end
          end
          default: begin
            res_next = '0;
          end
        endcase
      end
      S_SCAN: begin
        if (scan_hit) begin
          pend_next = 1'b0;
          case (cmd)
            CMD_INSERT: begin
              res_next.status = STAT_DUP;
            end
            CMD_LOOKUP: begin
              res_next.found          = 1'b1;
              res_next.result_address = rd_data.address;
            end
            default: begin
              // remove: start pulling later slots down one place
              idx_next = CNT_W'({1'b0, pend_idx} + 1'b1);
            end
          endcase
        end else if (scan_end) begin
          pend_next = 1'b0;
          if (cmd == CMD_INSERT) begin
            if (used_count == CNT_W'(CAPACITY)) begin
              res_next.status = STAT_FULL;
            end else begin
              mem_req.wr_en           = 1'b1;
              mem_req.wr_addr         = used_count[IDX_W-1:0];
              mem_req.wr_data.key     = key;
              mem_req.wr_data.address = ent_addr;
              used_count_next         = CNT_W'(used_count + 1'b1);
            end
          end else begin
            res_next.status = STAT_MISSING;
          end
        end else begin
          // issue the next slot read, compare it next cycle
          pend_next     = 1'b1;
          pend_idx_next = idx[IDX_W-1:0];
          idx_next      = CNT_W'(idx + 1'b1);
        end
      end
      S_SHIFT: begin
        if (pend) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = IDX_W'(pend_idx - 1'b1);
        end
        if (idx < used_count) begin
          pend_next     = 1'b1;
          pend_idx_next = idx[IDX_W-1:0];
          idx_next      = CNT_W'(idx + 1'b1);
        end else begin
          pend_next = 1'b0;
        end
        if (shift_done) begin
          used_count_next = CNT_W'(used_count - 1'b1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
        end
      end
      default: begin
        pend_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pend        <= 1'b0;
      used_count  <= '0;
      origin_live <= 1'b1;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      pend        <= pend_next;
      used_count  <= used_count_next;
      origin_live <= origin_live_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_key     <= KEY_W'(1);
      origin_address <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ORIGIN_KEY: begin
          origin_key <= cfg_data[KEY_W-1:0];
        end
        REG_ORIGIN_ADDRESS: begin
          origin_address <= cfg_data[ADDR_W-1:0];
        end
        default: begin
          origin_key <= origin_key;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    key      <= key_next;
    ent_addr <= ent_addr_next;
    idx      <= idx_next;
    pend_idx <= pend_idx_next;
    res      <= res_next;
    rsp      <= rsp_next;
  end

endmodule

FILE: sv/kat_checker.sv
// Port-level checks of the keyed address table, bound to the top level.
`include "keyed_address_table_unit_defines.svh"

module kat_checker
  import kat_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input kat_rsp_t             rsp
);

  // a stalled response word holds
  `KAT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response word changed while stalled")

  // one request at a time: busy right after an accept
  `KAT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request taken while busy")

  // a match always reports ok
  `KAT_ASSERT_NOW(a_found_ok, rsp_valid && rsp.found, rsp.status == STAT_OK, "found with non-ok status")

  // no match means no address
  `KAT_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp.found, rsp.result_address == '0, "address without a match")

endmodule

bind keyed_address_table_unit kat_checker u_kat_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

FILE: verif/testbench.sv
// Self-checking testbench for the keyed address table unit.
`timescale 1ns / 100ps

module testbench;
  import kat_pkg::*;

  // The fourth command code has no meaning in the block and must answer all zero.
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  // Register indexes past the two real registers; writes to them are ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int KEY_POOL_SIZE  = 20;
  // Settle time, sized for the slowest remove, a full-table compaction.
  localparam int SETTLE_CYCLES  = 2 * CAPACITY + 10;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_MASK, STALL_SLOW} stall_mode_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  kat_req_t             req       = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  kat_rsp_t             rsp;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  keyed_address_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mirror of the table contents and origin registers, advanced once per
  // accepted request word.
  logic [KEY_W-1:0]  mirror_keys  [CAPACITY];
  logic [ADDR_W-1:0] mirror_addrs [CAPACITY];
  int                mirror_count       = 0;
  logic              mirror_origin_live = 1'b1;
  logic [KEY_W-1:0]  mirror_origin_key  = 32'd1;
  logic [ADDR_W-1:0] mirror_origin_addr = 32'd0;

  kat_rsp_t          pending_responses[$];
  logic [KEY_W-1:0]  key_pool[KEY_POOL_SIZE];

  int burst_left     = 0;
  int sent_count     = 0;
  int checked_count  = 0;
  int mismatch_count = 0;
  int origin_setups  = 1;
  int found_count    = 0;
  int dup_count      = 0;
  int full_count     = 0;
  int missing_count  = 0;

  // Slot index holding key among the used slots, or -1.
  function automatic int find_mirror_slot(logic [KEY_W-1:0] key);
    for (int i = 0; i < mirror_count; i++) begin
      if (mirror_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Work out the response word for one request word and apply its effect
  // on the mirrored table.
  function automatic kat_rsp_t predict_table_response(kat_req_t word);
    kat_rsp_t resp;
    int       hit_slot;
    logic     origin_hit;
    resp        = '0;
    resp.status = STAT_OK;
    hit_slot    = find_mirror_slot(word.key);
    origin_hit  = mirror_origin_live && (word.key != '0) && (word.key == mirror_origin_key);
    case (word.command)
      CMD_INSERT: begin
        if (word.key == '0) begin
          resp.status = STAT_MISSING;
        end else if (origin_hit || hit_slot >= 0) begin
          resp.status = STAT_DUP;
        end else if (mirror_count >= CAPACITY) begin
          resp.status = STAT_FULL;
        end else begin
          mirror_keys[mirror_count]  = word.key;
          mirror_addrs[mirror_count] = word.entry_address;
          mirror_count++;
        end
      end
      CMD_REMOVE: begin
        if (word.key == '0) begin
          resp.status = STAT_MISSING;
        end else if (origin_hit && mirror_count == 0) begin
          mirror_origin_live = 1'b0;
        end else if (hit_slot < 0) begin
          resp.status = STAT_MISSING;
        end else begin
          // Close the gap: pull every later entry down one slot.
          for (int i = hit_slot; i < mirror_count - 1; i++) begin
            mirror_keys[i]  = mirror_keys[i + 1];
            mirror_addrs[i] = mirror_addrs[i + 1];
          end
          mirror_count--;
        end
      end
      CMD_LOOKUP: begin
        if (origin_hit) begin
          resp.found          = 1'b1;
          resp.result_address = mirror_origin_addr;
        end else if (word.key != '0 && hit_slot >= 0) begin
          resp.found          = 1'b1;
          resp.result_address = mirror_addrs[hit_slot];
        end else begin
          resp.status = STAT_MISSING;
        end
      end
      default: ;
    endcase
    return resp;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH response %0d %s: got %h want %h", checked_count, what, got, want);
    mismatch_count++;
  endtask

  // Offer one request word, hold it until taken, then record its expected
  // response. Bursts end in a random gap with valid low.
  task automatic send_request(input kat_req_t word);
    req       <= word;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pending_responses.push_back(predict_table_response(word));
    sent_count++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      // One burst in four is a long stretch with no idling at all.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
    end
  endtask

  task automatic issue_command(input logic [1:0] command, input logic [KEY_W-1:0] key,
                               input logic [ADDR_W-1:0] address);
    kat_req_t word;
    word.command       = command;
    word.key           = key;
    word.entry_address = address;
    send_request(word);
  endtask

  // Drop valid, wait out every pending response, then let the block settle.
  task automatic wait_until_idle();
    req_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (index == REG_ORIGIN_KEY) mirror_origin_key = value;
    else if (index == REG_ORIGIN_ADDRESS) mirror_origin_addr = value;
  endtask

  // Reprogram the origin while idle; also poke the unused indexes, which
  // must leave everything alone.
  task automatic set_origin(input logic [KEY_W-1:0] key, input logic [ADDR_W-1:0] address);
    wait_until_idle();
    write_register(REG_ORIGIN_KEY, key);
    write_register(REG_ORIGIN_ADDRESS, address);
    write_register(REG_SPARE_A, $urandom());
    write_register(REG_SPARE_B, $urandom());
    origin_setups++;
  endtask

  // Keys that recur within a phase, so inserts, removes and lookups collide.
  function automatic void refresh_key_pool();
    key_pool[0] = mirror_origin_key;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'd1;
    for (int i = 3; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom();
  endfunction

  function automatic kat_req_t random_request(int insert_weight, bit keep_origin);
    kat_req_t word;
    int       roll;
    int       pick;
    int       addr_roll;
    roll = $urandom_range(0, 99);
    if (roll < insert_weight) word.command = CMD_INSERT;
    else if (roll < insert_weight + (95 - insert_weight) / 2) word.command = CMD_REMOVE;
    else if (roll < 95) word.command = CMD_LOOKUP;
    else word.command = CMD_RESERVED;
    // Removes and lookups aim at a stored key 45 times in 100 when the table holds any.
    pick = $urandom_range(0, 99);
    if (pick < 45 && mirror_count > 0 && word.command != CMD_INSERT)
      word.key = mirror_keys[$urandom_range(0, mirror_count - 1)];
    else if (pick < 85) word.key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    else if (pick < 95) word.key = $urandom();
    else word.key = '0;
    addr_roll = $urandom_range(0, 9);
    if (addr_roll == 0) word.entry_address = '0;
    else if (addr_roll == 1) word.entry_address = '1;
    else word.entry_address = $urandom();
    // Keep the origin alive: an origin remove on an empty table would kill it.
    if (keep_origin && word.command == CMD_REMOVE && mirror_origin_live &&
        word.key == mirror_origin_key && mirror_count == 0)
      word.command = CMD_LOOKUP;
    return word;
  endfunction

  // Alternate insert-heavy and remove-heavy stretches so the table swings
  // between full and empty; pause once mid-phase until all responses are in.
  task automatic run_random_mix(input int count, input bit keep_origin);
    int pause_at;
    int insert_weight;
    pause_at      = $urandom_range(count / 4, 3 * count / 4);
    insert_weight = 65;
    refresh_key_pool();
    for (int n = 0; n < count; n++) begin
      if (n % 30 == 0) insert_weight = ((n / 30) % 2 == 0) ? 65 : 20;
      if (n == pause_at) wait_until_idle();
      send_request(random_request(insert_weight, keep_origin));
    end
  endtask

  // Edge cases at the reset origin (key 1, address 0) on an empty table.
  task automatic test_directed_edges();
    issue_command(CMD_LOOKUP, 32'd1, 32'd0);                // origin hit
    issue_command(CMD_INSERT, 32'd1, 32'hFFFF_FFFF);        // origin key is a duplicate
    issue_command(CMD_INSERT, 32'd0, 32'h1234_5678);        // null key
    issue_command(CMD_REMOVE, 32'd0, 32'd0);
    issue_command(CMD_LOOKUP, 32'd0, 32'd0);
    issue_command(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_command(CMD_INSERT, 32'hFFFF_FFFF, 32'd0);        // stored key is a duplicate
    issue_command(CMD_INSERT, 32'd2, 32'd0);                // zero address is legal
    issue_command(CMD_INSERT, 32'd3, 32'h5555_AAAA);
    issue_command(CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0);
    issue_command(CMD_LOOKUP, 32'd2, 32'hFFFF_FFFF);
    issue_command(CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_command(CMD_REMOVE, 32'd1, 32'd0);                // origin stays, entries stored
    issue_command(CMD_LOOKUP, 32'd1, 32'd0);
    issue_command(CMD_REMOVE, 32'hFFFF_FFFF, 32'd0);        // head removal shifts the rest
    issue_command(CMD_LOOKUP, 32'd3, 32'd0);
    issue_command(CMD_REMOVE, 32'd7, 32'd0);
    issue_command(CMD_LOOKUP, 32'd7, 32'd0);
  endtask

  task automatic test_reset_origin_mix();
    run_random_mix(150, 1'b1);
  endtask

  task automatic test_high_origin();
    set_origin(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random_mix(150, 1'b1);
  endtask

  task automatic test_low_origin();
    set_origin(32'd1, 32'd0);
    run_random_mix(150, 1'b1);
  endtask

  task automatic test_random_origin();
    logic [KEY_W-1:0] key;
    do key = $urandom(); while (key == '0);
    set_origin(key, $urandom());
    run_random_mix(150, 1'b1);
  endtask

  // Empty the table, clear the origin, then reuse its key as a plain entry.
  task automatic test_origin_clear();
    logic [KEY_W-1:0] key;
    logic [ADDR_W-1:0] address;
    do key = $urandom(); while (key == '0);
    address = $urandom();
    set_origin(key, address);
    while (mirror_count > 0) issue_command(CMD_REMOVE, mirror_keys[0], $urandom());
    issue_command(CMD_LOOKUP, key, 32'd0);                  // still live
    issue_command(CMD_REMOVE, key, 32'd0);                  // clears the origin
    issue_command(CMD_LOOKUP, key, 32'd0);                  // dead origin: not found
    issue_command(CMD_INSERT, key, ~address);               // now an ordinary entry
    issue_command(CMD_LOOKUP, key, 32'd0);
    issue_command(CMD_REMOVE, key, 32'd0);
    issue_command(CMD_REMOVE, key, 32'd0);                  // neither entry nor origin
    run_random_mix(120, 1'b0);
    // The origin register no longer matters, but must still take a write.
    set_origin(32'hFFFF_FFFF, 32'd0);
    run_random_mix(30, 1'b0);
  endtask

  // Compare each accepted response word against the oldest expectation.
  always @(posedge clk) begin : response_checker
    kat_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("arrived with nothing pending", rsp.result_address, 32'd0);
      end else begin
        want = pending_responses.pop_front();
        if (rsp.found !== want.found)
          report_mismatch("found", 32'(rsp.found), 32'(want.found));
        if (rsp.result_address !== want.result_address)
          report_mismatch("result_address", rsp.result_address, want.result_address);
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        if (want.found) found_count++;
        case (want.status)
          STAT_DUP:     dup_count++;
          STAT_FULL:    full_count++;
          STAT_MISSING: missing_count++;
          default: ;
        endcase
      end
      checked_count++;
    end
  end

  // Response-side back-pressure: switch among always-ready, coin-flip,
  // a rotating mask and a slow periodic pulse.
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_span  = 0;
  logic [15:0] stall_mask  = 16'h0001;
  int          slow_period = 4;
  int          slow_phase  = 0;

  always @(posedge clk) begin : response_stall
    if (stall_span == 0) begin
      stall_mode  = stall_mode_t'($urandom_range(0, 3));
      stall_span  = $urandom_range(20, 200);
      stall_mask  = 16'($urandom()) | 16'h0001;
      slow_period = $urandom_range(2, 12);
    end
    stall_span--;
    stall_mask = {stall_mask[14:0], stall_mask[15]};
    slow_phase = (slow_phase + 1) % slow_period;
    case (stall_mode)
      STALL_NONE:   rsp_ready <= 1'b1;
      STALL_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
      STALL_MASK:   rsp_ready <= stall_mask[0];
      default:      rsp_ready <= (slow_phase == 0);
    endcase
  end

  // End the run if no word moves on either channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Watchdog: %0d cycles with no word moving, %0d responses pending",
             WATCHDOG_LIMIT, pending_responses.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : test_sequence
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_reset_origin_mix();
    test_high_origin();
    test_low_origin();
    test_random_origin();
    test_origin_clear();
    wait_until_idle();
    $display("Covered %0d requests over %0d origin settings, %0d responses checked",
             sent_count, origin_setups, checked_count);
    $display("Responses seen: %0d found, %0d duplicate, %0d full, %0d not found, %0d mismatches",
             found_count, dup_count, full_count, missing_count, mismatch_count);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/kat_pkg.sv
sv/kat_table.sv
sv/kat_ctrl.sv
sv/keyed_address_table_unit.sv
sv/kat_checker.sv
verif/testbench.sv
